// ===== hw/rtl/lpht_pkg.sv =====
`timescale 1ns / 1ps

package lpht_pkg;

    // Default geometry of the table.
    localparam int DEFAULT_CAPACITY    = 64;
    localparam int DEFAULT_VALUE_WIDTH = 32;

    // Fixed field widths of the request and result items.
    localparam int KEY_W       = 32;
    localparam int VALUE_IN_W  = 32;
    localparam int VALUE_OUT_W = 32;
    localparam int STATUS_W    = 3;

    // The home slot remainder is built this many key bits per cycle.
    localparam int MOD_BITS  = 4;
    localparam int MOD_STEPS = KEY_W / MOD_BITS;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS);

    typedef enum logic [STATUS_W-1:0] {
        ST_NEW     = 3'd0,
        ST_UPDATED = 3'd1,
        ST_HIT     = 3'd2,
        ST_MISS    = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_ISSUE,
        S_CHECK,
        S_DONE
    } state_t;

    // Outcome of examining one probed slot.
    typedef struct packed {
        logic    stop;
        logic    write;
        logic    count_up;
        status_t status;
    } probe_res_t;

endpackage

// ===== hw/rtl/linear_probe_hash_table_unit.sv =====
`timescale 1ns / 1ps

// Linear-probing key/value table with a single-port-write, single-port-read slot memory.
// Requests arrive on the s_ channel: s_tuser carries the request type (lookup or insert),
// s_tdata carries the signed key and the value word. Each request produces exactly one
// result item on the m_ channel: m_tuser carries the status code and m_tdata the value
// found by a lookup hit (zero for every other outcome).
// The block works on one request at a time. A request is taken in the idle state, then,
// when CAPACITY is not a power of two, passes through the remainder unit that forms the
// home slot (four key bits per cycle); it then issues the first slot read, probes the
// slots in turn, and moves the result into the output register.
// The single slot memory read port sets the pace of the probe walk: one slot per cycle.
// After reset the block runs a clearing pass that writes each slot in turn and marks every
// slot empty; s_tready stays low until it ends.
// The result sits in an output register. While the receiver stalls, the block may still
// accept and work through the next request, but it holds that result until the output
// register is free, and it accepts nothing further meanwhile.
module linear_probe_hash_table_unit
#(
    parameter int CAPACITY    = lpht_pkg::DEFAULT_CAPACITY,
    parameter int VALUE_WIDTH = lpht_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [63:0]                       s_tdata,   // key [31:0], value_in [63:32]
    input  logic [0:0]                        s_tuser,   // req_type [0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lpht_pkg::VALUE_OUT_W-1:0]  m_tdata,   // value_out [31:0]
    output logic [lpht_pkg::STATUS_W-1:0]     m_tuser    // status [2:0]
);

    import lpht_pkg::*;

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int ENTRY_W = 1 + KEY_W + VALUE_WIDTH;
    localparam bit IS_POW2 = (CAPACITY == (1 << IDX_W));
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    // Slot memory: {valid, key, value}.
    logic [ENTRY_W-1:0] mem [CAPACITY];
    logic [ENTRY_W-1:0] rd_q_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;

    state_t state_reg, state_next;

    logic                    insert_reg, insert_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    logic [VALUE_WIDTH-1:0]  val_reg, val_next;
    logic [KEY_W-1:0]        mag_reg, mag_next;
    logic [IDX_W-1:0]        rem_reg, rem_next;
    logic [MOD_CNT_W-1:0]    mod_cnt_reg, mod_cnt_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [IDX_W-1:0]        chk_idx_reg, chk_idx_next;
    logic [IDX_W-1:0]        probe_n_reg, probe_n_next;
    logic [IDX_W-1:0]        clr_idx_reg, clr_idx_next;
    logic [CNT_W-1:0]        entry_count_reg, entry_count_next;
    status_t                 res_status_reg, res_status_next;
    logic [VALUE_OUT_W-1:0]  res_value_reg, res_value_next;
    logic                    m_valid_reg, m_valid_next;
    status_t                 m_status_reg, m_status_next;
    logic [VALUE_OUT_W-1:0]  m_value_reg, m_value_next;

    logic                   in_fire;
    logic                   out_free;
    logic [KEY_W-1:0]       in_key;
    logic [KEY_W-1:0]       in_mag;
    logic [IDX_W-1:0]       rem_step;
    logic                   slot_used;
    logic                   slot_match;
    logic [KEY_W-1:0]       slot_key;
    logic [VALUE_WIDTH-1:0] slot_val;
    logic                   probe_last;
    probe_res_t             probe;

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_status_reg;

    // Magnitude of the signed key; the most negative key maps to zero.
    assign in_key = s_tdata[KEY_W-1:0];
    always_comb
    begin
        if (in_key == {1'b1, {(KEY_W-1){1'b0}}})
        begin
            in_mag = '0;
        end
        else if (in_key[KEY_W-1])
        begin
            in_mag = KEY_W'(0) - in_key;
        end
        else
        begin
            in_mag = in_key;
        end
    end

    // Remainder unit: shifts in MOD_BITS bits of the magnitude, most significant first,
    // with a compare and subtract after each bit.
    always_comb
    begin
        logic [IDX_W:0] t;
        t = '0;
        rem_step = rem_reg;
        for (int b = 0; b < MOD_BITS; b++)
        begin
            t = {rem_step, mag_reg[KEY_W-1-b]};
            if (t >= (IDX_W+1)'(CAPACITY))
            begin
                t = t - (IDX_W+1)'(CAPACITY);
            end
            rem_step = t[IDX_W-1:0];
        end
    end

    // Examination of the slot whose read data is in rd_q_reg.
    assign slot_used  = rd_q_reg[ENTRY_W-1];
    assign slot_key   = rd_q_reg[VALUE_WIDTH +: KEY_W];
    assign slot_val   = rd_q_reg[VALUE_WIDTH-1:0];
    assign slot_match = slot_used && (slot_key == key_reg);
    assign probe_last = (probe_n_reg == LAST_IDX);

    always_comb
    begin
        probe = '{stop: 1'b0, write: 1'b0, count_up: 1'b0, status: ST_MISS};
        if (insert_reg)
        begin
            if (!slot_used || slot_match)
            begin
                probe.stop     = 1'b1;
                probe.write    = 1'b1;
                probe.count_up = !slot_match && (entry_count_reg < CNT_W'(CAPACITY));
                probe.status   = slot_match ? ST_UPDATED : ST_NEW;
            end
            else if (probe_last)
            begin
                probe.stop   = 1'b1;
                probe.status = ST_FULL;
            end
        end
        else
        begin
            if (slot_match)
            begin
                probe.stop   = 1'b1;
                probe.status = ST_HIT;
            end
            else if (!slot_used || probe_last)
            begin
                probe.stop   = 1'b1;
                probe.status = ST_MISS;
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = IS_POW2 ? S_ISSUE : S_MOD;
                end
            end
            S_MOD:
            begin
                if (mod_cnt_reg == MOD_CNT_W'(MOD_STEPS - 1))
                begin
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (probe.stop)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        insert_next      = insert_reg;
        key_next         = key_reg;
        val_next         = val_reg;
        mag_next         = mag_reg;
        rem_next         = rem_reg;
        mod_cnt_next     = mod_cnt_reg;
        idx_next         = idx_reg;
        chk_idx_next     = chk_idx_reg;
        probe_n_next     = probe_n_reg;
        clr_idx_next     = clr_idx_reg;
        entry_count_next = entry_count_reg;
        res_status_next  = res_status_reg;
        res_value_next   = res_value_reg;
        m_status_next    = m_status_reg;
        m_value_next     = m_value_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        mem_we           = 1'b0;
        mem_waddr        = chk_idx_reg;
        mem_wdata        = {1'b1, key_reg, val_reg};
        mem_raddr        = idx_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_idx_reg;
                mem_wdata    = '0;
                clr_idx_next = clr_idx_reg + IDX_W'(1);
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    insert_next  = s_tuser[0];
                    key_next     = in_key;
                    val_next     = VALUE_WIDTH'(s_tdata[KEY_W +: VALUE_IN_W]);
                    mag_next     = in_mag;
                    rem_next     = '0;
                    mod_cnt_next = '0;
                    idx_next     = in_mag[IDX_W-1:0];
                end
            end
            S_MOD:
            begin
                rem_next     = rem_step;
                mag_next     = mag_reg << MOD_BITS;
                mod_cnt_next = mod_cnt_reg + MOD_CNT_W'(1);
                idx_next     = rem_step;
            end
            S_ISSUE:
            begin
                // Read the home slot and point at the one after it.
                chk_idx_next = idx_reg;
                probe_n_next = '0;
                idx_next     = (idx_reg == LAST_IDX) ? '0 : idx_reg + IDX_W'(1);
            end
            S_CHECK:
            begin
                // Check the slot read last cycle while the next one is read.
                chk_idx_next = idx_reg;
                probe_n_next = probe_n_reg + IDX_W'(1);
                idx_next     = (idx_reg == LAST_IDX) ? '0 : idx_reg + IDX_W'(1);
                if (probe.stop)
                begin
                    mem_we          = probe.write;
                    res_status_next = probe.status;
                    res_value_next  = (probe.status == ST_HIT) ?
                                      VALUE_OUT_W'(slot_val) : '0;
                    if (probe.count_up)
                    begin
                        entry_count_next = entry_count_reg + CNT_W'(1);
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_value_next  = res_value_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_q_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_idx_reg     <= '0;
            entry_count_reg <= '0;
            m_valid_reg     <= 1'b0;
            mod_cnt_reg     <= '0;
            probe_n_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_idx_reg     <= clr_idx_next;
            entry_count_reg <= entry_count_next;
            m_valid_reg     <= m_valid_next;
            mod_cnt_reg     <= mod_cnt_next;
            probe_n_reg     <= probe_n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        insert_reg     <= insert_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        mag_reg        <= mag_next;
        rem_reg        <= rem_next;
        idx_reg        <= idx_next;
        chk_idx_reg    <= chk_idx_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        m_status_reg   <= m_status_next;
        m_value_reg    <= m_value_next;
    end

    // The number of stored keys never exceeds the number of slots.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    // Outside the clearing pass, only an insert writes the slot memory.
    a_write_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg != S_CLEAR) |-> insert_reg)
        else $error("slot memory written by a lookup");

    // The result kind agrees with the request kind.
    a_status_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |->
        (insert_reg ? (res_status_reg == ST_NEW || res_status_reg == ST_UPDATED ||
                       res_status_reg == ST_FULL)
                    : (res_status_reg == ST_HIT || res_status_reg == ST_MISS)))
        else $error("result status does not fit the request type");

    // Only a lookup hit returns a nonzero value.
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_status_reg != ST_HIT) |-> (m_value_reg == '0))
        else $error("nonzero value on a result other than a hit");

    // The entry count moves only on the cycle a new key is stored.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_CHECK || !probe.count_up) |=>
        (entry_count_reg == $past(entry_count_reg)))
        else $error("entry count changed without a new key");

endmodule

// ===== tb/lpht_tb_pkg.sv =====
`timescale 1ns / 1ps

package lpht_tb_pkg;

    // Request type codes carried in s_tuser.
    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

endpackage

// ===== tb/linear_probe_hash_table_checker.sv =====
`timescale 1ns / 1ps

module linear_probe_hash_table_checker
#(
    parameter int CAPACITY    = lpht_pkg::DEFAULT_CAPACITY,
    parameter int VALUE_WIDTH = lpht_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [63:0]                      s_tdata,   // key [31:0], value_in [63:32]
    input  logic [0:0]                       s_tuser,   // req_type [0]
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [lpht_pkg::VALUE_OUT_W-1:0] m_tdata,   // value_out [31:0]
    input  logic [lpht_pkg::STATUS_W-1:0]    m_tuser,   // status [2:0]
    output int unsigned                      error_count,
    output int unsigned                      outstanding
);

    import lpht_pkg::*;
    import lpht_tb_pkg::*;

    typedef struct packed {
        status_t                status;
        logic [VALUE_OUT_W-1:0] value;
    } answer_t;

    // Shadow copy of the table contents.
    logic [KEY_W-1:0]       shadow_key   [CAPACITY];
    logic [VALUE_WIDTH-1:0] shadow_value [CAPACITY];
    bit                     shadow_used  [CAPACITY];
    int unsigned            shadow_entries;

    answer_t     answer_fifo[$];
    answer_t     oldest;
    int unsigned mismatches;
    int unsigned results_seen;

    assign error_count = mismatches;

    function automatic int unsigned home_of(logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] mag;
        if (k == 32'h8000_0000)
        begin
            return 0;
        end
        mag = k[KEY_W-1] ? -k : k;
        return mag % CAPACITY;
    endfunction

    // Walks the shadow table the way the block does and applies any insert.
    function automatic answer_t probe_table(logic req, logic [KEY_W-1:0] k,
                                            logic [VALUE_IN_W-1:0] v);
        int unsigned slot;
        answer_t     ans;
        slot       = home_of(k);
        ans.status = (req == REQ_INSERT) ? ST_FULL : ST_MISS;
        ans.value  = '0;
        for (int n = 0; n < CAPACITY; n++)
        begin
            if (req == REQ_INSERT)
            begin
                if (!shadow_used[slot] || shadow_key[slot] == k)
                begin
                    ans.status = shadow_used[slot] ? ST_UPDATED : ST_NEW;
                    if (!shadow_used[slot] && shadow_entries < CAPACITY)
                    begin
                        shadow_entries++;
                    end
                    shadow_key[slot]   = k;
                    shadow_value[slot] = VALUE_WIDTH'(v);
                    shadow_used[slot]  = 1'b1;
                    break;
                end
            end
            else
            begin
                if (!shadow_used[slot])
                begin
                    break;
                end
                if (shadow_key[slot] == k)
                begin
                    ans.status = ST_HIT;
                    ans.value  = VALUE_OUT_W'(shadow_value[slot]);
                    break;
                end
            end
            slot = (slot + 1) % CAPACITY;
        end
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                shadow_used[i] = 1'b0;
            end
            shadow_entries = 0;
            answer_fifo.delete();
            mismatches   = 0;
            results_seen = 0;
            outstanding <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                answer_fifo.push_back(probe_table(s_tuser[0], s_tdata[31:0], s_tdata[63:32]));
            end
            if (m_tvalid && m_tready)
            begin
                if (answer_fifo.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("result %0d: unexpected item, status %0d value %h",
                                 results_seen, m_tuser, m_tdata);
                    end
                end
                else
                begin
                    oldest = answer_fifo.pop_front();
                    if (m_tuser !== oldest.status || m_tdata !== oldest.value)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display({"result %0d: expected status %0d value %h, ",
                                      "got status %0d value %h"},
                                     results_seen, oldest.status, oldest.value,
                                     m_tuser, m_tdata);
                        end
                    end
                end
                results_seen++;
            end
            outstanding <= answer_fifo.size();
        end
    end

endmodule

// ===== tb/linear_probe_hash_table_unit_test.sv =====
`timescale 1ns / 1ps

module linear_probe_hash_table_unit_test;
    import lpht_pkg::*;
    import lpht_tb_pkg::*;

    localparam int CAPACITY = lpht_pkg::DEFAULT_CAPACITY;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [63:0]            s_tdata;   // key [31:0], value_in [63:32]
    logic [0:0]             s_tuser;   // req_type [0]
    logic                   m_tvalid;
    logic                   m_tready;
    logic [VALUE_OUT_W-1:0] m_tdata;   // value_out [31:0]
    logic [STATUS_W-1:0]    m_tuser;   // status [2:0]

    int unsigned fail_count;
    int unsigned outstanding;

    // Keys the table holds right now, tracked so that the fill phase knows
    // when every slot is taken.
    bit          known_keys[logic [31:0]];
    // A modest set of keys with clustered home slots, reused so that inserts
    // turn into updates and lookups mostly hit.
    logic [31:0] key_pool[$];
    int unsigned items_sent;
    bit          no_gaps;
    int unsigned gap;
    int unsigned ready_run;
    int unsigned ready_stall;
    int unsigned roll;

    linear_probe_hash_table_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    linear_probe_hash_table_checker results_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .error_count (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The slowest legal run is well under a third of this time: a lookup of an absent key
    // on a full table walks all slots, and both sides may stall for a while.
    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int unsigned idle_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // A key whose home slot falls in the lowest sixteen slots, so that the
    // probe runs grow long and wrap-around gets exercised.
    function automatic logic [31:0] clustered_key();
        logic [31:0] mag;
        mag      = $urandom;
        mag[31]  = 1'b0;
        mag[5:0] = 6'($urandom_range(0, 15));
        return ($urandom_range(0, 1) == 1) ? -mag : mag;
    endfunction

    // Offers one item and holds it until the block takes it. When a gap
    // follows, valid drops and the data bus carries junk that must be ignored.
    // With no gap, valid simply stays high into the next item.
    task automatic send_request(input logic req, input logic [31:0] k, input logic [31:0] v);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {v, k};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        if (req == REQ_INSERT && (known_keys.exists(k) || known_keys.num() < CAPACITY))
        begin
            known_keys[k] = 1'b1;
        end
        items_sent++;
        if (items_sent % 64 == 0)
        begin
            no_gaps = ($urandom_range(0, 4) == 0);
        end
        gap = no_gaps ? 0 : idle_cycles();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom};
            s_tuser  <= 1'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    // The receiver accepts in bursts of random length and stalls in between.
    // Some bursts are long enough to leave the result side free of stalls.
    initial
    begin
        m_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            m_tready <= 1'b1;
            ready_run = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 24);
            repeat (ready_run) @(posedge clk);
            ready_stall = idle_cycles();
            if (ready_stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (ready_stall) @(posedge clk);
            end
        end
    end

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= REQ_LOOKUP;
        items_sent = 0;
        no_gaps    = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. The block holds off s_tready during its clearing
        // pass, so the first item simply waits for it.
        // A lookup on the empty table misses at once.
        send_request(REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        // Key zero and the most negative key share home slot zero, so the
        // second one probes into slot one.
        send_request(REQ_INSERT, 32'h0000_0000, 32'h0000_0000);
        send_request(REQ_INSERT, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(REQ_LOOKUP, 32'h8000_0000, 32'h0000_0000);
        // Keys one and minus one both land on slot one, which is taken.
        send_request(REQ_INSERT, 32'h0000_0001, 32'h1234_5678);
        send_request(REQ_INSERT, 32'hFFFF_FFFF, 32'h8765_4321);
        send_request(REQ_INSERT, 32'h0000_0040, 32'h0F0F_0F0F);
        // The largest key goes to the last slot; minus 63 hashes there too
        // and has to wrap round to the first free low slot.
        send_request(REQ_INSERT, 32'h7FFF_FFFF, 32'hF0F0_F0F0);
        send_request(REQ_INSERT, 32'hFFFF_FFC1, 32'h5555_5555);
        send_request(REQ_LOOKUP, 32'hFFFF_FFC1, 32'h0000_0000);
        // Updates of present keys, then lookups that see the new values.
        send_request(REQ_INSERT, 32'h0000_0000, 32'hA5A5_A5A5);
        send_request(REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_request(REQ_INSERT, 32'hFFFF_FFFF, 32'hAAAA_AAAA);
        send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        // Misses that probe past several occupied slots, one across the wrap, then a hit in the last slot.
        send_request(REQ_LOOKUP, 32'h0000_0080, 32'h0000_0000);
        send_request(REQ_LOOKUP, 32'hFFFF_FFC0, 32'h0000_0000);
        send_request(REQ_LOOKUP, 32'h8000_0001, 32'h0000_0000);
        send_request(REQ_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
        // The value word of a lookup is ignored.
        send_request(REQ_LOOKUP, 32'h0000_0001, 32'hDEAD_BEEF);

        key_pool.push_back(32'h8000_0000);
        key_pool.push_back(32'h7FFF_FFFF);
        key_pool.push_back(32'hFFFF_FFFF);
        key_pool.push_back(32'h0000_0000);
        while (key_pool.size() < 40)
        begin
            key_pool.push_back(clustered_key());
        end

        // Moderate load: the pool plus odd keys, which stop once 56 keys are known, keeps the table
        // short of full while the probe runs stay interesting.
        repeat (1050)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 45)
            begin
                send_request(REQ_INSERT, key_pool[$urandom_range(0, key_pool.size() - 1)],
                             $urandom);
            end
            else if (roll < 82)
            begin
                send_request(REQ_LOOKUP, key_pool[$urandom_range(0, key_pool.size() - 1)],
                             $urandom);
            end
            else if (roll < 94 || known_keys.num() >= 56)
            begin
                send_request(REQ_LOOKUP, $urandom, $urandom);
            end
            else
            begin
                send_request(REQ_INSERT, $urandom, $urandom);
            end
        end

        // Fill every remaining slot, with lookups mixed in along the way.
        while (known_keys.num() < CAPACITY)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                send_request(REQ_LOOKUP, key_pool[$urandom_range(0, key_pool.size() - 1)],
                             $urandom);
            end
            else
            begin
                send_request(REQ_INSERT, clustered_key(), $urandom);
            end
        end

        // Full table: new keys are refused, present keys still update, and a
        // lookup of an absent key wraps all the way round to a miss.
        repeat (400)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 30)
            begin
                send_request(REQ_INSERT, $urandom, $urandom);
            end
            else if (roll < 60)
            begin
                send_request(REQ_INSERT, key_pool[$urandom_range(0, key_pool.size() - 1)],
                             $urandom);
            end
            else if (roll < 85)
            begin
                send_request(REQ_LOOKUP, key_pool[$urandom_range(0, key_pool.size() - 1)],
                             $urandom);
            end
            else
            begin
                send_request(REQ_LOOKUP, $urandom, $urandom);
            end
        end

        s_tvalid <= 1'b0;
        // Let the checker's count catch up with the last item taken.
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        // A full-length probe walk plus margin, to catch any stray result.
        repeat (100) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
